@@ sv/seg_pkg.sv @@
`timescale 1ns / 1ps

package seg_pkg;

  localparam int TOL_W = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 32'd4295;

  typedef enum logic [1:0] {
    OC_CROSS      = 2'd0,
    OC_COINCIDENT = 2'd1,
    OC_PARALLEL   = 2'd2,
    OC_OUTSIDE    = 2'd3
  } outcome_e;

  typedef struct packed {
    logic     valid;
    outcome_e outcome;
    logic     neg_x;
    logic     neg_y;
  } ctrl_t;

endpackage

@@ sv/seg_front.sv @@
`timescale 1ns / 1ps

module seg_front import seg_pkg::*; #(
  parameter int CW = 32,
  parameter int MW = 2 * CW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [TOL_W-1:0]     tol_i,
  input  logic signed [CW-1:0] x1_i,
  input  logic signed [CW-1:0] y1_i,
  input  logic signed [CW-1:0] x2_i,
  input  logic signed [CW-1:0] y2_i,
  input  logic signed [CW-1:0] x3_i,
  input  logic signed [CW-1:0] y3_i,
  input  logic signed [CW-1:0] x4_i,
  input  logic signed [CW-1:0] y4_i,
  output ctrl_t                ctrl_o,
  output logic signed [CW-1:0] x1_o,
  output logic signed [CW-1:0] y1_o,
  output logic signed [CW-1:0] mid_x_o,
  output logic signed [CW-1:0] mid_y_o,
  output logic [MW-1:0]        num_mag_o,
  output logic [MW-1:0]        den_mag_o,
  output logic [CW-1:0]        dax_mag_o,
  output logic [CW-1:0]        day_mag_o
);

  localparam int D    = CW + 1;
  localparam int PW   = 2 * D;
  localparam int NW   = PW + 1;
  localparam int CMPW = (MW > TOL_W) ? MW : TOL_W;

  // stage 1: differences and midpoint
  logic [4:0] vld_q;
  logic signed [D-1:0]  dax1_q, day1_q, dbx1_q, dby1_q, sx1_q, sy1_q;
  logic signed [CW-1:0] x1_1_q, y1_1_q, mx1_q, my1_q;
  logic signed [D-1:0]  sumx, sumy;

  assign sumx = D'(x1_i) + D'(x2_i);
  assign sumy = D'(y1_i) + D'(y2_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax1_q <= D'(x2_i) - D'(x1_i);
      day1_q <= D'(y2_i) - D'(y1_i);
      dbx1_q <= D'(x4_i) - D'(x3_i);
      dby1_q <= D'(y4_i) - D'(y3_i);
      sx1_q  <= D'(x1_i) - D'(x3_i);
      sy1_q  <= D'(y1_i) - D'(y3_i);
      x1_1_q <= x1_i;
      y1_1_q <= y1_i;
      mx1_q  <= sumx[D-1:1];
      my1_q  <= sumy[D-1:1];
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_den_a_q, p_den_b_q, p_na_a_q, p_na_b_q, p_nb_a_q, p_nb_b_q;
  logic signed [D-1:0]  dax2_q, day2_q;
  logic signed [CW-1:0] x1_2_q, y1_2_q, mx2_q, my2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_den_a_q <= PW'(dby1_q) * PW'(dax1_q);
      p_den_b_q <= PW'(dbx1_q) * PW'(day1_q);
      p_na_a_q  <= PW'(dbx1_q) * PW'(sy1_q);
      p_na_b_q  <= PW'(dby1_q) * PW'(sx1_q);
      p_nb_a_q  <= PW'(dax1_q) * PW'(sy1_q);
      p_nb_b_q  <= PW'(day1_q) * PW'(sx1_q);
      dax2_q <= dax1_q;
      day2_q <= day1_q;
      x1_2_q <= x1_1_q;
      y1_2_q <= y1_1_q;
      mx2_q  <= mx1_q;
      my2_q  <= my1_q;
    end
  end

  // stage 3: den, na, nb
  logic signed [NW-1:0] den3_q, na3_q, nb3_q;
  logic signed [D-1:0]  dax3_q, day3_q;
  logic signed [CW-1:0] x1_3_q, y1_3_q, mx3_q, my3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den3_q <= NW'(p_den_a_q) - NW'(p_den_b_q);
      na3_q  <= NW'(p_na_a_q) - NW'(p_na_b_q);
      nb3_q  <= NW'(p_nb_a_q) - NW'(p_nb_b_q);
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      x1_3_q <= x1_2_q;
      y1_3_q <= y1_2_q;
      mx3_q  <= mx2_q;
      my3_q  <= my2_q;
    end
  end

  // stage 4: magnitudes and signs
  logic [MW-1:0]        den_m4_q, na_m4_q, nb_m4_q;
  logic                 den_s4_q, na_s4_q, nb_s4_q, na_z4_q, nb_z4_q, dax_s4_q, day_s4_q;
  logic [CW-1:0]        dax_m4_q, day_m4_q;
  logic signed [CW-1:0] x1_4_q, y1_4_q, mx4_q, my4_q;
  logic signed [NW-1:0] den_neg, na_neg, nb_neg;
  logic signed [D-1:0]  dax_neg, day_neg;

  assign den_neg = -den3_q;
  assign na_neg  = -na3_q;
  assign nb_neg  = -nb3_q;
  assign dax_neg = -dax3_q;
  assign day_neg = -day3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_m4_q <= den3_q[NW-1] ? den_neg[MW-1:0] : den3_q[MW-1:0];
      na_m4_q  <= na3_q[NW-1] ? na_neg[MW-1:0] : na3_q[MW-1:0];
      nb_m4_q  <= nb3_q[NW-1] ? nb_neg[MW-1:0] : nb3_q[MW-1:0];
      den_s4_q <= den3_q[NW-1];
      na_s4_q  <= na3_q[NW-1];
      nb_s4_q  <= nb3_q[NW-1];
      na_z4_q  <= (na3_q == '0);
      nb_z4_q  <= (nb3_q == '0);
      dax_m4_q <= dax3_q[D-1] ? dax_neg[CW-1:0] : dax3_q[CW-1:0];
      day_m4_q <= day3_q[D-1] ? day_neg[CW-1:0] : day3_q[CW-1:0];
      dax_s4_q <= dax3_q[D-1];
      day_s4_q <= day3_q[D-1];
      x1_4_q <= x1_3_q;
      y1_4_q <= y1_3_q;
      mx4_q  <= mx3_q;
      my4_q  <= my3_q;
    end
  end

  // stage 5: classify
  logic [CMPW-1:0] tol_ext;
  logic     nz_den, nz_na, nz_nb, in_a, in_b, neg_off;
  outcome_e oc;
  outcome_e oc_q;
  logic     neg_x_q, neg_y_q;

  assign tol_ext = CMPW'(tol_i);
  assign nz_den  = CMPW'(den_m4_q) <= tol_ext;
  assign nz_na   = CMPW'(na_m4_q) <= tol_ext;
  assign nz_nb   = CMPW'(nb_m4_q) <= tol_ext;
  // a zero numerator is inside for either sign of den
  assign in_a    = (na_z4_q || (na_s4_q == den_s4_q)) && (na_m4_q <= den_m4_q);
  assign in_b    = (nb_z4_q || (nb_s4_q == den_s4_q)) && (nb_m4_q <= den_m4_q);
  assign neg_off = na_s4_q != den_s4_q;

  always_comb begin
    if (nz_na && nz_nb && nz_den) begin
      oc = OC_COINCIDENT;
    end else if (nz_den) begin
      oc = OC_PARALLEL;
    end else if (!in_a || !in_b) begin
      oc = OC_OUTSIDE;
    end else begin
      oc = OC_CROSS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oc_q      <= oc;
      neg_x_q   <= neg_off ^ dax_s4_q;
      neg_y_q   <= neg_off ^ day_s4_q;
      num_mag_o <= na_m4_q;
      den_mag_o <= den_m4_q;
      dax_mag_o <= dax_m4_q;
      day_mag_o <= day_m4_q;
      x1_o    <= x1_4_q;
      y1_o    <= y1_4_q;
      mid_x_o <= mx4_q;
      mid_y_o <= my4_q;
    end
  end

  always_comb begin
    ctrl_o.valid   = vld_q[4];
    ctrl_o.outcome = oc_q;
    ctrl_o.neg_x   = neg_x_q;
    ctrl_o.neg_y   = neg_y_q;
  end

endmodule

@@ sv/seg_div.sv @@
`timescale 1ns / 1ps

// floor(num * d / den) with num <= den, one bit of d per stage, MSB first
module seg_div #(
  parameter int CW = 32,
  parameter int MW = 2 * CW + 2
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [MW-1:0] num_i,
  input  logic [MW-1:0] den_i,
  input  logic [CW-1:0] d_i,
  output logic [CW-1:0] q_o
);

  localparam int RW = MW + 2;

  logic [RW-1:0] r_q   [CW];
  logic [CW-1:0] q_q   [CW];
  logic [CW-1:0] d_q   [CW];
  logic [MW-1:0] num_q [CW];
  logic [MW-1:0] den_q [CW];

  for (genvar i = 0; i < CW; i++) begin : g_step
    logic [RW-1:0] r_in, t, den1, den2;
    logic [CW-1:0] q_in, d_in;
    logic [MW-1:0] num_in, den_in;
    logic [RW-1:0] r_d;
    logic [CW-1:0] q_d;

    if (i == 0) begin : g_first
      assign r_in   = '0;
      assign q_in   = '0;
      assign d_in   = d_i;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign r_in   = r_q[i-1];
      assign q_in   = q_q[i-1];
      assign d_in   = d_q[i-1];
      assign num_in = num_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign den1 = RW'(den_in);
    assign den2 = {den1[RW-2:0], 1'b0};
    assign t    = {r_in[RW-2:0], 1'b0} + (d_in[CW-1] ? RW'(num_in) : '0);

    // remainder stays below den, so t < 3*den and the digit is 0..2
    always_comb begin
      if (t >= den2) begin
        r_d = t - den2;
        q_d = {q_in[CW-2:0], 1'b0} + CW'(2);
      end else if (t >= den1) begin
        r_d = t - den1;
        q_d = {q_in[CW-2:0], 1'b1};
      end else begin
        r_d = t;
        q_d = {q_in[CW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i]   <= r_d;
        q_q[i]   <= q_d;
        d_q[i]   <= {d_in[CW-2:0], 1'b0};
        num_q[i] <= num_in;
        den_q[i] <= den_in;
      end
    end
  end

  assign q_o = q_q[CW-1];

endmodule

@@ sv/segment_intersection.sv @@
`timescale 1ns / 1ps
// Pipeline: five front stages, one long-division stage per coordinate bit and
// one output stage. Throughput: one beat per cycle unless out_ready_i stalls the
// output; the divider is fully pipelined.
// Reset: rst_ni clears all valid bits and restores tol_q to 4295.

module segment_intersection import seg_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_end_y_i,
  input  logic                          cfg_we_i,
  input  logic [TOL_W-1:0]              cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [1:0]                    outcome_o,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic signed [COORD_WIDTH-1:0] cross_y_o
);

  localparam int CW = COORD_WIDTH;
  localparam int MW = 2 * CW + 2;

  logic en;
  logic [TOL_W-1:0] tol_q;
  logic out_vld_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  ctrl_t f_ctrl;
  logic signed [CW-1:0] f_x1, f_y1, f_mx, f_my;
  logic [MW-1:0] f_num, f_den;
  logic [CW-1:0] f_dax, f_day, qx, qy;

  seg_front #(.CW(CW), .MW(MW)) u_front (
    .clk_i, .rst_ni,
    .en_i      (en),
    .valid_i   (in_valid_i),
    .tol_i     (tol_q),
    .x1_i      (a_start_x_i),
    .y1_i      (a_start_y_i),
    .x2_i      (a_end_x_i),
    .y2_i      (a_end_y_i),
    .x3_i      (b_start_x_i),
    .y3_i      (b_start_y_i),
    .x4_i      (b_end_x_i),
    .y4_i      (b_end_y_i),
    .ctrl_o    (f_ctrl),
    .x1_o      (f_x1),
    .y1_o      (f_y1),
    .mid_x_o   (f_mx),
    .mid_y_o   (f_my),
    .num_mag_o (f_num),
    .den_mag_o (f_den),
    .dax_mag_o (f_dax),
    .day_mag_o (f_day)
  );

  seg_div #(.CW(CW), .MW(MW)) u_div_x (
    .clk_i, .en_i(en), .num_i(f_num), .den_i(f_den), .d_i(f_dax), .q_o(qx)
  );

  seg_div #(.CW(CW), .MW(MW)) u_div_y (
    .clk_i, .en_i(en), .num_i(f_num), .den_i(f_den), .d_i(f_day), .q_o(qy)
  );

  // sideband delay matching the divider
  ctrl_t ctrl_q [CW];
  logic [CW-1:0] sb_vld_q;
  logic signed [CW-1:0] x1_q [CW];
  logic signed [CW-1:0] y1_q [CW];
  logic signed [CW-1:0] mx_q [CW];
  logic signed [CW-1:0] my_q [CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= '0;
    end else if (en) begin
      sb_vld_q <= {sb_vld_q[CW-2:0], f_ctrl.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < CW; i++) begin
        if (i == 0) begin
          ctrl_q[i] <= f_ctrl;
          x1_q[i]   <= f_x1;
          y1_q[i]   <= f_y1;
          mx_q[i]   <= f_mx;
          my_q[i]   <= f_my;
        end else begin
          ctrl_q[i] <= ctrl_q[i-1];
          x1_q[i]   <= x1_q[i-1];
          y1_q[i]   <= y1_q[i-1];
          mx_q[i]   <= mx_q[i-1];
          my_q[i]   <= my_q[i-1];
        end
      end
    end
  end

  // output stage
  ctrl_t ct;
  logic signed [CW-1:0] off_x, off_y;
  logic hit_d;
  logic signed [CW-1:0] cx_d, cy_d;

  assign ct    = ctrl_q[CW-1];
  assign off_x = ct.neg_x ? -$signed(qx) : $signed(qx);
  assign off_y = ct.neg_y ? -$signed(qy) : $signed(qy);

  always_comb begin
    case (ct.outcome)
      OC_CROSS: begin
        hit_d = 1'b1;
        cx_d  = x1_q[CW-1] + off_x;
        cy_d  = y1_q[CW-1] + off_y;
      end
      OC_COINCIDENT: begin
        hit_d = 1'b1;
        cx_d  = mx_q[CW-1];
        cy_d  = my_q[CW-1];
      end
      default: begin
        hit_d = 1'b0;
        cx_d  = '0;
        cy_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sb_vld_q[CW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o     <= hit_d;
      outcome_o <= ct.outcome;
      cross_x_o <= cx_d;
      cross_y_o <= cy_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ sv/seg_checker.sv @@
`timescale 1ns / 1ps

module seg_checker import seg_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   hit_o,
  input logic [1:0]             outcome_o,
  input logic [COORD_WIDTH-1:0] cross_x_o,
  input logic [COORD_WIDTH-1:0] cross_y_o
);

  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (outcome_o == OC_CROSS || outcome_o == OC_COINCIDENT)))
    else $error("hit disagrees with outcome");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (cross_x_o == '0 && cross_y_o == '0))
    else $error("point not zero on a miss");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready not tied to output stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hit_o) &&
      $stable(outcome_o) && $stable(cross_x_o) && $stable(cross_y_o)))
    else $error("stalled result changed");

endmodule

bind segment_intersection seg_checker #(.COORD_WIDTH(COORD_WIDTH)) u_seg_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .hit_o, .outcome_o, .cross_x_o, .cross_y_o
);
